@@ hdl/g2pb_pkg.sv @@
package g2pb_pkg;

  localparam int ACCUM_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int CNT_W     = 16;
  localparam int QUOT_W    = 16;
  localparam int ROOT_W    = 8;
  localparam int LANES     = 3;

  localparam int DIV_STEPS  = QUOT_W;
  localparam int PIPE_DEPTH = 1 + DIV_STEPS + ROOT_W;

  localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 16'd1;

  typedef logic [QUOT_W-1:0] quot_t;
  typedef logic [ROOT_W-1:0] root_t;

endpackage

@@ hdl/gamma2_pixel_to_byte_core.sv @@
// Gamma-2 pixel conversion: accumulated RGB sums to 8-bit bytes.
//
// Input channel (in_valid/in_ready): one pixel per transfer, red, green
// and blue sums as unsigned fixed point with FRAC_BITS fraction bits, and
// a last-pixel flag. Output channel (out_valid/out_ready): the three bytes
// min(255, isqrt(sum / sample_count)) and frame_end, a copy of the flag.
// Config channel (cfg_valid/cfg_ready): writes sample_count; it is always
// ready and must only be written while no pixel is in flight.
//
// Each color has its own lane: a pipelined restoring divider (an input
// register, then 16 stages of one quotient bit each) followed by an
// 8-stage square root pipeline. The output register merges the lanes.
// Throughput is one pixel per clock while the output is not stalled.
//
// When out_valid is high and out_ready is low, the whole pipeline holds
// and in_ready drops in the same cycle. Reset (rst_n low, synchronous)
// empties the pipeline and sets sample_count to 1.
module gamma2_pixel_to_byte_core #(
  parameter int ACCUM_BITS = g2pb_pkg::ACCUM_BITS_DEF,
  parameter int FRAC_BITS  = g2pb_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ACCUM_BITS-1:0]      in_red_sum,
  input  logic [ACCUM_BITS-1:0]      in_green_sum,
  input  logic [ACCUM_BITS-1:0]      in_blue_sum,
  input  logic                       in_last_pixel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_red_byte,
  output logic [7:0]                 out_green_byte,
  output logic [7:0]                 out_blue_byte,
  output logic                       out_frame_end,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [g2pb_pkg::CNT_W-1:0] cfg_sample_count
);

  localparam int DEPTH = g2pb_pkg::PIPE_DEPTH;
  localparam int NL    = g2pb_pkg::LANES;

  logic                       en;
  logic [g2pb_pkg::CNT_W-1:0] sample_count_r;
  logic [DEPTH-1:0]           vld_r;
  logic [DEPTH-1:0]           flag_r;
  logic                       out_valid_r;
  logic                       frame_end_r;

  logic [ACCUM_BITS-1:0]      sum_a  [NL];
  g2pb_pkg::quot_t            quot_a [NL];
  g2pb_pkg::root_t            root_a [NL];
  g2pb_pkg::root_t            byte_r [NL];

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  assign sum_a[0] = in_red_sum;
  assign sum_a[1] = in_green_sum;
  assign sum_a[2] = in_blue_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= g2pb_pkg::SAMPLE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      sample_count_r <= cfg_sample_count;
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    g2pb_div_lane #(
      .ACCUM_BITS (ACCUM_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_div (
      .clk          (clk),
      .en           (en),
      .sum          (sum_a[l]),
      .sample_count (sample_count_r),
      .quot         (quot_a[l])
    );

    g2pb_sqrt_lane u_sqrt (
      .clk  (clk),
      .en   (en),
      .val  (quot_a[l]),
      .root (root_a[l])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        byte_r[l] <= root_a[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[DEPTH-2:0], in_valid};
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag_r      <= {flag_r[DEPTH-2:0], in_last_pixel};
      frame_end_r <= flag_r[DEPTH-1];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_byte   = byte_r[0];
  assign out_green_byte = byte_r[1];
  assign out_blue_byte  = byte_r[2];
  assign out_frame_end  = frame_end_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while output stalled");

  a_transfer_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("input transfer lost at pipeline entry");

  a_drain_clears_output: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !vld_r[DEPTH-1]) |=> !out_valid_r)
    else $error("output transfer repeated");

  a_pipe_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(vld_r))
    else $error("pipeline moved during output stall");

endmodule

@@ hdl/g2pb_div_lane.sv @@
module g2pb_div_lane #(
  parameter int ACCUM_BITS = g2pb_pkg::ACCUM_BITS_DEF,
  parameter int FRAC_BITS  = g2pb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ACCUM_BITS-1:0]         sum,
  input  logic [g2pb_pkg::CNT_W-1:0]    sample_count,
  output g2pb_pkg::quot_t               quot
);

  localparam int SHL   = (FRAC_BITS <= 16) ? 16 - FRAC_BITS : 0;
  localparam int SHD   = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int NUM_W = ACCUM_BITS + SHL;
  localparam int DEN_W = g2pb_pkg::CNT_W + SHD;
  localparam int HI_W  = (NUM_W > 16) ? NUM_W - 16 : 1;
  localparam int NX_W  = HI_W + 16;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int STEPS = g2pb_pkg::DIV_STEPS;

  logic [DEN_W-1:0]  den;
  logic [NX_W-1:0]   num_x;
  logic [HI_W-1:0]   num_hi;
  logic              sat_nxt;

  // per-stage state: partial remainder, unconsumed numerator bits, quotient bits
  logic [DEN_W-1:0]        rem_r [STEPS];
  logic [15:0]             low_r [STEPS];
  g2pb_pkg::quot_t         q_r   [STEPS+1];
  logic                    sat_r [STEPS+1];

  assign den     = DEN_W'(sample_count) << SHD;
  assign num_x   = NX_W'(sum) << SHL;
  assign num_hi  = num_x[NX_W-1:16];
  // quotient of 2^16 or more, or a zero divisor
  assign sat_nxt = CMP_W'(num_hi) >= CMP_W'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= sat_nxt;
      rem_r[0] <= DEN_W'(num_hi);
      low_r[0] <= num_x[15:0];
      q_r[0]   <= '0;
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_r[s], low_r[s][15]};
    assign diff  = trial - {1'b0, den};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        sat_r[s+1] <= sat_r[s];
        q_r[s+1]   <= {q_r[s][g2pb_pkg::QUOT_W-2:0], ge};
      end
    end

    if (s < STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          low_r[s+1] <= {low_r[s][14:0], 1'b0};
        end
      end
    end
  end

  assign quot = sat_r[STEPS] ? '1 : q_r[STEPS];

endmodule

@@ hdl/g2pb_sqrt_lane.sv @@
module g2pb_sqrt_lane (
  input  logic            clk,
  input  logic            en,
  input  g2pb_pkg::quot_t val,
  output g2pb_pkg::root_t root
);

  localparam int RW = g2pb_pkg::ROOT_W;

  g2pb_pkg::root_t root_r [1:RW];
  g2pb_pkg::quot_t val_r  [1:RW-1];

  for (genvar j = 0; j < RW; j++) begin : g_digit
    g2pb_pkg::root_t root_in;
    g2pb_pkg::quot_t val_in;
    g2pb_pkg::root_t cand;
    g2pb_pkg::quot_t sq;

    if (j == 0) begin : g_first
      assign root_in = '0;
      assign val_in  = val;
    end else begin : g_next
      assign root_in = root_r[j];
      assign val_in  = val_r[j];
    end

    assign cand = root_in | (g2pb_pkg::root_t'(1) << (RW - 1 - j));
    assign sq   = g2pb_pkg::quot_t'(cand) * g2pb_pkg::quot_t'(cand);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[j+1] <= (sq <= val_in) ? cand : root_in;
      end
    end

    if (j < RW - 1) begin : g_val
      always_ff @(posedge clk) begin
        if (en) begin
          val_r[j+1] <= val_in;
        end
      end
    end
  end

  assign root = root_r[RW];

endmodule
